>>> src/zss_pkg.sv
`default_nettype none
package zss_pkg;

   localparam int MAX_FEATURES_DEF = 16;
   localparam int MAX_SAMPLES_DEF  = 4096;

   localparam int VAL_W  = 24;
   localparam int CNT_W  = 13;
   localparam int SUM_W  = 36;
   localparam int SQ_W   = 60;
   localparam int FEAT_W = 4;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 3;
   localparam int FIU_W  = 5;
   localparam int CSR_IDX_W = 1;

   localparam int ALU_W   = 80;
   localparam int ALU_B_W = 64;
   localparam int ITER_W  = 7;

   localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FINISH    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TRANSFORM = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FITTED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_FEATURE = 3'd2;
   localparam logic [STAT_W-1:0] ST_FEW_SAMPLES = 3'd3;
   localparam logic [STAT_W-1:0] ST_ZERO_SCALE  = 3'd4;
   localparam logic [STAT_W-1:0] ST_COUNT_FULL  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_FEATURES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SCALE = 1'd1;

   localparam logic [VAL_W-1:0] Q_MAX = 24'h7FFFFF;
   localparam logic [VAL_W-1:0] Q_MIN = 24'h800000;

   localparam logic [ITER_W-1:0] ITER_SAMPLE = 7'd24;
   localparam logic [ITER_W-1:0] ITER_COUNT  = 7'd13;
   localparam logic [ITER_W-1:0] ITER_SUM    = 7'd36;
   localparam logic [ITER_W-1:0] ITER_VAR    = 7'd80;
   localparam logic [ITER_W-1:0] ITER_SQRT   = 7'd32;
   localparam logic [ITER_W-1:0] ITER_XFORM  = 7'd41;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [FEAT_W-1:0]       feature;
      logic signed [VAL_W-1:0] value;
   } zss_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [FEAT_W-1:0]       feature_out;
      logic signed [VAL_W-1:0] result;
   } zss_rsp_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } zss_mode_type;

   typedef struct packed {
      logic               go;
      zss_mode_type       mode;
      logic [ITER_W-1:0]  iters;
      logic [ALU_W-1:0]   opa;
      logic [ALU_B_W-1:0] opb;
      logic [ALU_W-1:0]   init;
   } zss_alu_cmd_type;

   typedef struct packed {
      logic             done;
      logic [ALU_W-1:0] value;
   } zss_alu_res_type;

endpackage
`default_nettype wire

>>> src/zss_ram.sv
`default_nettype none
module zss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> src/zss_alu.sv
`default_nettype none
module zss_alu (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire zss_pkg::zss_alu_cmd_type cmd,
   output zss_pkg::zss_alu_res_type     res
);

   logic                           active_ff;
   logic                           done_ff;
   logic [zss_pkg::ITER_W-1:0]     cnt_ff;
   zss_pkg::zss_mode_type          mode_ff;
   logic [zss_pkg::ALU_W-1:0]      p_ff;
   logic [zss_pkg::ALU_W-1:0]      mc_ff;
   logic [zss_pkg::ALU_B_W-1:0]    mp_ff;
   logic [35:0]                    r_ff;

   logic [24:0]                    div_rs;
   logic [35:0]                    sq_rs;
   logic [33:0]                    sq_t;
   logic [zss_pkg::ALU_W-1:0]      opx;
   logic [zss_pkg::ALU_W-1:0]      opy;
   logic                           sub;
   logic [zss_pkg::ALU_W:0]        sum;
   logic                           ge;

   assign div_rs = {r_ff[23:0], mc_ff[79]};
   assign sq_rs  = {r_ff[33:0], mc_ff[79:78]};
   assign sq_t   = {p_ff[31:0], 2'b01};

   // one shared adder: accumulate for multiply, trial subtract for divide and root
   always_comb begin
      case (mode_ff)
         zss_pkg::ALU_MUL: begin
            opx = p_ff;
            opy = mp_ff[0] ? mc_ff : '0;
            sub = 1'b0;
         end
         zss_pkg::ALU_DIV: begin
            opx = {55'd0, div_rs};
            opy = {56'd0, mp_ff[23:0]};
            sub = 1'b1;
         end
         zss_pkg::ALU_SQRT: begin
            opx = {44'd0, sq_rs};
            opy = {46'd0, sq_t};
            sub = 1'b1;
         end
         default: begin
            opx = '0;
            opy = '0;
            sub = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + {80'd0, sub};
   assign ge  = sum[80];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            active_ff <= 1'b1;
            cnt_ff    <= cmd.iters;
            mode_ff   <= cmd.mode;
            p_ff      <= cmd.init;
            mc_ff     <= cmd.opa;
            mp_ff     <= cmd.opb;
            r_ff      <= '0;
         end else if (active_ff) begin
            case (mode_ff)
               zss_pkg::ALU_MUL: begin
                  p_ff  <= sum[79:0];
                  mc_ff <= {mc_ff[78:0], 1'b0};
                  mp_ff <= {1'b0, mp_ff[63:1]};
               end
               zss_pkg::ALU_DIV: begin
                  r_ff  <= ge ? {11'd0, sum[24:0]} : {11'd0, div_rs};
                  p_ff  <= {p_ff[78:0], ge};
                  mc_ff <= {mc_ff[78:0], 1'b0};
               end
               zss_pkg::ALU_SQRT: begin
                  r_ff  <= ge ? sum[35:0] : sq_rs;
                  p_ff  <= {p_ff[78:0], ge};
                  mc_ff <= {mc_ff[77:0], 2'b00};
               end
               default: begin
                  p_ff <= p_ff;
               end
            endcase
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign res.done  = done_ff;
   assign res.value = p_ff;

endmodule
`default_nettype wire

>>> src/zscore_standardizer.sv
`default_nettype none
// Per-feature z-score standardizer. A request is taken when start is high and busy is low;
// its one response appears for a single cycle with rsp_valid and must be captured then,
// as the receiver cannot stall it. Multiplies, divides and square roots run through one
// shared shift-add unit that retires one bit per cycle (two radicand bits for the square
// root): a fit sample uses a 24-step multiply, a transform a 41-step divide, and a finish,
// for each feature in use, multiplies of 13, 36 and 13 steps, an 80-step divide, a 32-step
// root and a 36-step divide for the mean. Bad-feature, not-fitted and reserved requests,
// and a finish with no features in use, answer in the next cycle. Accumulators are
// cleared at once through per-feature valid bits, with no clearing pass.
module zscore_standardizer #(
   parameter int MAX_FEATURES = zss_pkg::MAX_FEATURES_DEF,
   parameter int MAX_SAMPLES  = zss_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire zss_pkg::zss_req_type              req_payload,
   output logic                                   rsp_valid,
   output zss_pkg::zss_rsp_type                   rsp_payload,
   input  wire logic                              csr_we,
   input  wire logic [zss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [zss_pkg::VAL_W-1:0]         csr_wdata
);

   localparam int AW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int FAW   = $clog2(2 * MAX_FEATURES);
   localparam int UW    = $clog2(MAX_FEATURES + 1);
   localparam int ACC_W = zss_pkg::SUM_W + zss_pkg::SQ_W + zss_pkg::CNT_W;
   localparam int FIT_W = 2 * zss_pkg::VAL_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRD,
      S_SMUL,
      S_FADDR,
      S_FRD,
      S_FMUL1,
      S_FMUL2,
      S_FMUL3,
      S_FDIV1,
      S_FSQRT,
      S_FDIV2,
      S_TRD,
      S_TDIV
   } state_type;

   state_type                        state_ff;
   logic [zss_pkg::FIU_W-1:0]        fiu_ff;
   logic [zss_pkg::VAL_W-1:0]        min_scale_ff;
   logic                             is_fitted_ff;
   logic [MAX_FEATURES-1:0]          valid_ff;
   logic [MAX_FEATURES-1:0]          bank_ff;
   logic [MAX_FEATURES-1:0]          pend_ff;
   zss_pkg::zss_req_type             req_ff;
   logic [UW-1:0]                    j_ff;
   logic [zss_pkg::CNT_W-1:0]        n_ff;
   logic signed [zss_pkg::SUM_W-1:0] s1_ff;
   logic [zss_pkg::ALU_W-1:0]        a_ff;
   logic [zss_pkg::VAL_W-1:0]        scale_ff;
   logic                             neg_ff;
   logic                             rsp_valid_ff;
   zss_pkg::zss_rsp_type             rsp_ff;
   zss_pkg::zss_alu_cmd_type         alu_cmd_ff;
   logic [AW-1:0]                    acc_raddr_ff;

   zss_pkg::zss_alu_res_type         alu_res;
   logic [UW-1:0]                    used;
   logic                             feat_bad;
   logic [AW-1:0]                    req_idx;
   logic [AW-1:0]                    acc_raddr;
   logic [ACC_W-1:0]                 acc_rdata;
   logic [ACC_W-1:0]                 acc_rd;
   logic signed [zss_pkg::SUM_W-1:0] acc_s1;
   logic [zss_pkg::SQ_W-1:0]         acc_s2;
   logic [zss_pkg::CNT_W-1:0]        acc_n;
   logic                             acc_we;
   logic [ACC_W-1:0]                 acc_wdata;
   logic [FAW-1:0]                   fit_raddr;
   logic [FAW-1:0]                   fit_waddr;
   logic [FIT_W-1:0]                 fit_rdata;
   logic [FIT_W-1:0]                 fit_wdata;
   logic                             fit_we;
   logic [zss_pkg::VAL_W-1:0]        xmag;
   logic [zss_pkg::SUM_W-1:0]        s1mag;
   logic [zss_pkg::ALU_W-1:0]        var_diff;
   logic [63:0]                      sat64;
   logic [zss_pkg::VAL_W-1:0]        sig;
   logic [zss_pkg::VAL_W-1:0]        mean_q;
   logic [zss_pkg::VAL_W-1:0]        fit_mean;
   logic [zss_pkg::VAL_W:0]          t_diff;
   logic [zss_pkg::VAL_W:0]          t_mag;
   logic [zss_pkg::VAL_W-1:0]        t_fit_mean;
   logic [zss_pkg::VAL_W-1:0]        t_fit_scale;
   logic [zss_pkg::VAL_W-1:0]        xform_res;
   logic [zss_pkg::VAL_W-1:0]        zero_res;
   logic [MAX_FEATURES-1:0]          pend_now;

   always_comb begin
      if (32'(fiu_ff) > MAX_FEATURES) begin
         used = UW'(MAX_FEATURES);
      end else begin
         used = UW'(fiu_ff);
      end
   end

   assign feat_bad = 32'(req_payload.feature) >= 32'(used);
   assign req_idx  = AW'(req_payload.feature);

   // accumulator store, entries without a valid bit read as zero
   assign acc_raddr = (state_ff == S_IDLE) ? req_idx : j_ff[AW-1:0];
   assign acc_rd    = valid_ff[acc_raddr_ff] ? acc_rdata : '0;
   assign acc_s1    = acc_rd[ACC_W-1 -: zss_pkg::SUM_W];
   assign acc_s2    = acc_rd[zss_pkg::CNT_W +: zss_pkg::SQ_W];
   assign acc_n     = acc_rd[zss_pkg::CNT_W-1:0];

   assign acc_we    = (state_ff == S_SMUL) && alu_res.done;
   assign acc_wdata = {s1_ff + {{(zss_pkg::SUM_W - zss_pkg::VAL_W){req_ff.value[23]}},
                                req_ff.value},
                       alu_res.value[zss_pkg::SQ_W-1:0],
                       n_ff + 13'd1};

   zss_ram #(.WIDTH(ACC_W), .DEPTH(MAX_FEATURES)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (AW'(req_ff.feature)),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   // fitted values are double banked so a failed finish leaves the old fit intact
   assign fit_raddr = FAW'({bank_ff[req_idx], req_idx});
   assign fit_waddr = FAW'({~bank_ff[j_ff[AW-1:0]], j_ff[AW-1:0]});
   assign mean_q    = alu_res.value[zss_pkg::VAL_W-1:0];
   assign fit_mean  = s1_ff[zss_pkg::SUM_W-1] ? (~mean_q + 24'd1) : mean_q;
   assign fit_wdata = {fit_mean, scale_ff};
   assign fit_we    = (state_ff == S_FDIV2) && alu_res.done;
   assign pend_now  = pend_ff | (MAX_FEATURES'(1) << j_ff[AW-1:0]);

   zss_ram #(.WIDTH(FIT_W), .DEPTH(2 * MAX_FEATURES)) u_fit_ram (
      .clock (clock),
      .we    (fit_we),
      .waddr (fit_waddr),
      .wdata (fit_wdata),
      .raddr (fit_raddr),
      .rdata (fit_rdata)
   );

   zss_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd_ff),
      .res   (alu_res)
   );

   assign xmag  = req_ff.value[23] ? (~req_ff.value + 24'd1) : req_ff.value;
   assign s1mag = s1_ff[zss_pkg::SUM_W-1] ? (~s1_ff + 36'd1) : s1_ff;

   // n*S2 - S1^2, clamped at zero
   assign var_diff = (a_ff >= alu_res.value) ? (a_ff - alu_res.value) : '0;
   assign sat64    = (|alu_res.value[79:64]) ? '1 : alu_res.value[63:0];
   assign sig      = (|alu_res.value[31:24]) ? '1 : alu_res.value[23:0];

   assign t_fit_mean  = fit_rdata[FIT_W-1 -: zss_pkg::VAL_W];
   assign t_fit_scale = fit_rdata[zss_pkg::VAL_W-1:0];
   assign t_diff = {req_ff.value[23], req_ff.value} - {t_fit_mean[23], t_fit_mean};
   assign t_mag  = t_diff[24] ? (~t_diff + 25'd1) : t_diff;
   assign zero_res = (t_diff == '0) ? '0 : (t_diff[24] ? zss_pkg::Q_MIN : zss_pkg::Q_MAX);

   always_comb begin
      if (neg_ff) begin
         xform_res = (alu_res.value > 80'd8388608) ? zss_pkg::Q_MIN :
                     (~alu_res.value[23:0] + 24'd1);
      end else begin
         xform_res = (alu_res.value > 80'd8388607) ? zss_pkg::Q_MAX :
                     alu_res.value[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fiu_ff        <= 5'd16;
         min_scale_ff  <= 24'd1;
         is_fitted_ff  <= 1'b0;
         valid_ff      <= '0;
         bank_ff       <= '0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         alu_cmd_ff.go <= 1'b0;
      end else begin
         rsp_valid_ff  <= 1'b0;
         alu_cmd_ff.go <= 1'b0;
         acc_raddr_ff  <= acc_raddr;

         if (csr_we) begin
            case (csr_index)
               zss_pkg::CSR_FEATURES:  fiu_ff <= csr_wdata[zss_pkg::FIU_W-1:0];
               zss_pkg::CSR_MIN_SCALE: min_scale_ff <= csr_wdata;
               default:                fiu_ff <= fiu_ff;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_payload;
                  rsp_ff.feature_out <= req_payload.feature;
                  rsp_ff.result      <= '0;
                  rsp_ff.status      <= zss_pkg::ST_OK;
                  case (req_payload.cmd)
                     zss_pkg::CMD_SAMPLE: begin
                        if (feat_bad) begin
                           rsp_ff.status <= zss_pkg::ST_BAD_FEATURE;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_SRD;
                        end
                     end
                     zss_pkg::CMD_FINISH: begin
                        rsp_ff.feature_out <= '0;
                        j_ff <= '0;
                        if (used == '0) begin
                           is_fitted_ff <= 1'b1;
                           valid_ff     <= '0;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= S_FADDR;
                        end
                     end
                     zss_pkg::CMD_TRANSFORM: begin
                        if (!is_fitted_ff) begin
                           rsp_ff.status <= zss_pkg::ST_NOT_FITTED;
                           rsp_valid_ff  <= 1'b1;
                        end else if (feat_bad) begin
                           rsp_ff.status <= zss_pkg::ST_BAD_FEATURE;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_TRD;
                        end
                     end
                     default: begin
                        rsp_ff.feature_out <= '0;
                        rsp_valid_ff       <= 1'b1;
                     end
                  endcase
               end
            end

            S_SRD: begin
               s1_ff <= acc_s1;
               n_ff  <= acc_n;
               if (32'(acc_n) >= MAX_SAMPLES) begin
                  rsp_ff.status <= zss_pkg::ST_COUNT_FULL;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  // S2 rides in as the accumulator start value
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_MUL;
                  alu_cmd_ff.iters <= zss_pkg::ITER_SAMPLE;
                  alu_cmd_ff.opa   <= {56'd0, xmag};
                  alu_cmd_ff.opb   <= {40'd0, xmag};
                  alu_cmd_ff.init  <= {20'd0, acc_s2};
                  state_ff         <= S_SMUL;
               end
            end

            S_SMUL: begin
               if (alu_res.done) begin
                  valid_ff[AW'(req_ff.feature)] <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end

            S_FADDR: begin
               state_ff <= S_FRD;
            end

            S_FRD: begin
               s1_ff <= acc_s1;
               n_ff  <= acc_n;
               if (acc_n < 13'd2) begin
                  rsp_ff.status      <= zss_pkg::ST_FEW_SAMPLES;
                  rsp_ff.feature_out <= zss_pkg::FEAT_W'(j_ff);
                  rsp_valid_ff       <= 1'b1;
                  is_fitted_ff       <= 1'b0;
                  valid_ff           <= '0;
                  pend_ff            <= '0;
                  state_ff           <= S_IDLE;
               end else begin
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_MUL;
                  alu_cmd_ff.iters <= zss_pkg::ITER_COUNT;
                  alu_cmd_ff.opa   <= {20'd0, acc_s2};
                  alu_cmd_ff.opb   <= {51'd0, acc_n};
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_FMUL1;
               end
            end

            S_FMUL1: begin
               if (alu_res.done) begin
                  a_ff             <= alu_res.value;
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_MUL;
                  alu_cmd_ff.iters <= zss_pkg::ITER_SUM;
                  alu_cmd_ff.opa   <= {44'd0, s1mag};
                  alu_cmd_ff.opb   <= {28'd0, s1mag};
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_FMUL2;
               end
            end

            S_FMUL2: begin
               if (alu_res.done) begin
                  a_ff             <= var_diff;
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_MUL;
                  alu_cmd_ff.iters <= zss_pkg::ITER_COUNT;
                  alu_cmd_ff.opa   <= {67'd0, n_ff};
                  alu_cmd_ff.opb   <= {51'd0, n_ff - 13'd1};
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_FMUL3;
               end
            end

            S_FMUL3: begin
               if (alu_res.done) begin
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_DIV;
                  alu_cmd_ff.iters <= zss_pkg::ITER_VAR;
                  alu_cmd_ff.opa   <= a_ff;
                  alu_cmd_ff.opb   <= {40'd0, alu_res.value[23:0]};
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_FDIV1;
               end
            end

            S_FDIV1: begin
               if (alu_res.done) begin
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_SQRT;
                  alu_cmd_ff.iters <= zss_pkg::ITER_SQRT;
                  alu_cmd_ff.opa   <= {sat64, 16'd0};
                  alu_cmd_ff.opb   <= '0;
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_FSQRT;
               end
            end

            S_FSQRT: begin
               if (alu_res.done) begin
                  if (sig < min_scale_ff) begin
                     rsp_ff.status      <= zss_pkg::ST_ZERO_SCALE;
                     rsp_ff.feature_out <= zss_pkg::FEAT_W'(j_ff);
                     rsp_valid_ff       <= 1'b1;
                     is_fitted_ff       <= 1'b0;
                     valid_ff           <= '0;
                     pend_ff            <= '0;
                     state_ff           <= S_IDLE;
                  end else begin
                     scale_ff         <= sig;
                     alu_cmd_ff.go    <= 1'b1;
                     alu_cmd_ff.mode  <= zss_pkg::ALU_DIV;
                     alu_cmd_ff.iters <= zss_pkg::ITER_SUM;
                     alu_cmd_ff.opa   <= {s1mag, 44'd0};
                     alu_cmd_ff.opb   <= {51'd0, n_ff};
                     alu_cmd_ff.init  <= '0;
                     state_ff         <= S_FDIV2;
                  end
               end
            end

            S_FDIV2: begin
               if (alu_res.done) begin
                  if (j_ff + UW'(1) == used) begin
                     bank_ff      <= bank_ff ^ pend_now;
                     pend_ff      <= '0;
                     is_fitted_ff <= 1'b1;
                     valid_ff     <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     pend_ff  <= pend_now;
                     j_ff     <= j_ff + UW'(1);
                     state_ff <= S_FADDR;
                  end
               end
            end

            S_TRD: begin
               neg_ff <= t_diff[24];
               if (t_fit_scale == '0) begin
                  rsp_ff.result <= zero_res;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  alu_cmd_ff.go    <= 1'b1;
                  alu_cmd_ff.mode  <= zss_pkg::ALU_DIV;
                  alu_cmd_ff.iters <= zss_pkg::ITER_XFORM;
                  alu_cmd_ff.opa   <= {t_mag, 55'd0};
                  alu_cmd_ff.opb   <= {40'd0, t_fit_scale};
                  alu_cmd_ff.init  <= '0;
                  state_ff         <= S_TDIV;
               end
            end

            S_TDIV: begin
               if (alu_res.done) begin
                  rsp_ff.result <= xform_res;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // an accepted request either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   a_result_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.result != '0)) |-> (rsp_payload.status == zss_pkg::ST_OK))
      else $error("nonzero result with error status");

   a_fit_with_ok: assert property (@(posedge clock) disable iff (reset)
      $rose(is_fitted_ff) |-> (rsp_valid_ff && (rsp_ff.status == zss_pkg::ST_OK)))
      else $error("fit taken without a successful finish response");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      alu_res.done |-> ((state_ff == S_SMUL) || (state_ff == S_FMUL1) ||
                        (state_ff == S_FMUL2) || (state_ff == S_FMUL3) ||
                        (state_ff == S_FDIV1) || (state_ff == S_FSQRT) ||
                        (state_ff == S_FDIV2) || (state_ff == S_TDIV)))
      else $error("arithmetic unit finished outside a wait state");

endmodule
`default_nettype wire
